// ===== design/swa_pkg.sv =====
// Shared types and constants of the sliding window identifier allocator.
package swa_pkg;

    localparam int WINDOW_BYTES_DEF = 4;
    localparam int ID_SPACE_DEF     = 65536;

    localparam int ID_W     = 16;
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;

    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ID_W-1:0]     id;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] new_id;
        logic            is_valid;
        logic            full_res;
        logic            ignored;
    } result_t;

endpackage

// ===== design/swa_in_reg.sv =====
// Input register: holds one accepted word until the result stage takes it.
module swa_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  swa_pkg::item_t  item,
    input  logic            advance,
    output logic            item_valid,
    output swa_pkg::item_t  item_q
);

    logic           valid_reg;
    swa_pkg::item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item_q     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== design/swa_core.sv =====
// Allocator state (window start, next free id, release bitmap) and per-word logic.
module swa_core
#(
    parameter int WINDOW_BYTES = swa_pkg::WINDOW_BYTES_DEF,
    parameter int ID_SPACE     = swa_pkg::ID_SPACE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  swa_pkg::item_t   item,
    output swa_pkg::result_t result
);

    localparam int SPAN_BITS = WINDOW_BYTES * swa_pkg::BYTE_W;
    localparam int OFF_W     = $clog2(SPAN_BITS);
    localparam int CNT_W     = swa_pkg::ID_W + 1;
    localparam int LIMIT_I   = (SPAN_BITS < ID_SPACE - 1) ? SPAN_BITS : ID_SPACE - 1;

    localparam logic [CNT_W-1:0] SPACE_C = CNT_W'(ID_SPACE);
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT_I);
    localparam logic [CNT_W-1:0] SPAN_C  = CNT_W'(SPAN_BITS);
    localparam logic [CNT_W-1:0] BYTE_C  = CNT_W'(swa_pkg::BYTE_W);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [swa_pkg::ID_W-1:0] ws_reg, ws_next;
    logic [swa_pkg::ID_W-1:0] nf_reg, nf_next;
    logic [SPAN_BITS-1:0]     bits_reg, bits_next;

    logic [CNT_W-1:0]     ws_ext, nf_ext, id_ext;
    logic [CNT_W-1:0]     live, rel_pos, nf_inc, ws_inc, ws_wrap;
    logic                 in_window;
    logic [OFF_W-1:0]     off;
    logic [SPAN_BITS-1:0] set_bits;

    always_comb
    begin
        ws_ext = {1'b0, ws_reg};
        nf_ext = {1'b0, nf_reg};
        id_ext = {1'b0, item.id};

        live    = (nf_ext >= ws_ext) ? (nf_ext - ws_ext) : (SPACE_C - ws_ext + nf_ext);
        rel_pos = (id_ext >= ws_ext) ? (id_ext - ws_ext) : (SPACE_C - ws_ext + id_ext);

        in_window = (id_ext < SPACE_C) && (rel_pos < live) && (rel_pos < SPAN_C);
        off       = rel_pos[OFF_W-1:0];
        set_bits  = bits_reg | (SPAN_BITS'(1) << off);

        nf_inc  = nf_ext + ONE_C;
        ws_inc  = ws_ext + BYTE_C;
        ws_wrap = ws_inc - SPACE_C;
    end

    always_comb
    begin
        ws_next   = ws_reg;
        nf_next   = nf_reg;
        bits_next = bits_reg;
        result    = '0;
        unique case (item.opcode)
            swa_pkg::OP_ALLOC:
            begin
                if (live >= LIMIT_C)
                begin
                    result.full_res = 1'b1;
                end
                else
                begin
                    result.new_id = nf_reg;
                    nf_next = (nf_inc >= SPACE_C) ? '0 : nf_inc[swa_pkg::ID_W-1:0];
                end
            end
            swa_pkg::OP_QUERY:
            begin
                result.is_valid = in_window && !bits_reg[off];
            end
            swa_pkg::OP_RELEASE:
            begin
                if (!in_window)
                begin
                    result.ignored = 1'b1;
                end
                else if ((rel_pos < BYTE_C) && (&set_bits[swa_pkg::BYTE_W-1:0]))
                begin
                    // first byte complete: drop it and slide the window by eight
                    bits_next = set_bits >> swa_pkg::BYTE_W;
                    ws_next   = (ws_inc >= SPACE_C) ? ws_wrap[swa_pkg::ID_W-1:0]
                                                    : ws_inc[swa_pkg::ID_W-1:0];
                end
                else
                begin
                    bits_next = set_bits;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= '0;
            nf_reg   <= '0;
            bits_reg <= '0;
        end
        else if (fire)
        begin
            ws_reg   <= ws_next;
            nf_reg   <= nf_next;
            bits_reg <= bits_next;
        end
    end

endmodule

// ===== design/swa_out_reg.sv =====
// Result register: holds a finished word until the consumer takes it.
module swa_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  swa_pkg::result_t result,
    input  logic             out_stall,
    output logic             advance,
    output logic             out_valid,
    output swa_pkg::result_t result_q
);

    logic             valid_reg;
    swa_pkg::result_t result_reg;

    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result_q  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== design/sliding_window_id_allocator_unit.sv =====
// An accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while out_stall is low; the state update of one word and
// its result are one pass of logic between the input register and the result register.
// Reset (rst_n low, asynchronous): window start, next free id and release bitmap clear,
// both pipeline registers empty; no clearing pass, words are taken right after reset.
module sliding_window_id_allocator_unit
#(
    parameter int WINDOW_BYTES = swa_pkg::WINDOW_BYTES_DEF,
    parameter int ID_SPACE     = swa_pkg::ID_SPACE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [swa_pkg::OPCODE_W-1:0]  opcode,
    input  logic [swa_pkg::ID_W-1:0]      id,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swa_pkg::ID_W-1:0]      new_id,
    output logic                          is_valid,
    output logic                          full_res,
    output logic                          ignored
);

    swa_pkg::item_t   item_in;
    swa_pkg::item_t   item_q;
    swa_pkg::result_t result;
    swa_pkg::result_t result_q;
    logic             item_valid;
    logic             advance;
    logic             fire;

    assign item_in.opcode = opcode;
    assign item_in.id     = id;

    // Advance the held word into the state logic whenever the result register can take it.
    assign fire = item_valid && advance;

    swa_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_q     (item_q)
    );

    // Window state and the allocate / query / release decode live here.
    swa_core
    #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .ID_SPACE     (ID_SPACE)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_q),
        .result (result)
    );

    // Hold the result while the consumer stalls; the input register keeps accepting
    // as long as this stage can drain.
    swa_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .result_q   (result_q)
    );

    assign new_id   = result_q.new_id;
    assign is_valid = result_q.is_valid;
    assign full_res = result_q.full_res;
    assign ignored  = result_q.ignored;

endmodule

// ===== design/swa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module swa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [swa_pkg::ID_W-1:0]      new_id,
    input logic                          is_valid,
    input logic                          full_res,
    input logic                          ignored
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_id) && $stable(is_valid)
            && $stable(full_res) && $stable(ignored))
        else $error("result word changed while stalled");

    // input backs up only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // an accepted word reaches the output when the output then drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted word did not reach the output");

    // at most one status flag, and a refused allocate gives no id
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({is_valid, full_res, ignored}) <= 1)
            && (!full_res || (new_id == '0)))
        else $error("inconsistent result flags");

endmodule

bind sliding_window_id_allocator_unit swa_checker u_swa_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_id    (new_id),
    .is_valid  (is_valid),
    .full_res  (full_res),
    .ignored   (ignored)
);
